[design/podf_pkg.sv]
// ============================================================================
// podf_pkg
// Shared constants, types and register codes of the profile occlusion and
// density filter.
// ============================================================================
package podf_pkg;

    // Sizing
    localparam int MAX_RUN      = 16;
    localparam int COORD_BITS   = 32;
    localparam int CFG_BITS     = 21;
    localparam int RUN_CFG_BITS = 5;
    localparam int CFG_IDX_BITS = 3;
    localparam int SLOT_BITS    = $clog2(MAX_RUN);
    localparam int RUN_BITS     = $clog2(MAX_RUN + 1);
    localparam int CMP_BITS     = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 2;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MIN_STEP_X    = 3'd0,
        REG_DROP_STEP_Y   = 3'd1,
        REG_DROP_WINDOW_X = 3'd2,
        REG_RISE_STEP_Y   = 3'd3,
        REG_RISE_WINDOW_X = 3'd4,
        REG_JUMP_LIMIT    = 3'd5,
        REG_RUN_LENGTH    = 3'd6
    } cfg_index_t;

    // Register reset values
    localparam logic [CFG_BITS-1:0]     RST_MIN_STEP_X    = 21'd328;
    localparam logic [CFG_BITS-1:0]     RST_DROP_STEP_Y   = 21'd66;
    localparam logic [CFG_BITS-1:0]     RST_DROP_WINDOW_X = 21'd2621;
    localparam logic [CFG_BITS-1:0]     RST_RISE_STEP_Y   = 21'd66;
    localparam logic [CFG_BITS-1:0]     RST_RISE_WINDOW_X = 21'd655;
    localparam logic [CFG_BITS-1:0]     RST_JUMP_LIMIT    = 21'd6554;
    localparam logic [RUN_CFG_BITS-1:0] RST_RUN_LENGTH    = 5'd10;

    typedef struct packed {
        logic [CFG_BITS-1:0]     min_step_x;
        logic [CFG_BITS-1:0]     drop_step_y;
        logic [CFG_BITS-1:0]     drop_window_x;
        logic [CFG_BITS-1:0]     rise_step_y;
        logic [CFG_BITS-1:0]     rise_window_x;
        logic [CFG_BITS-1:0]     jump_limit;
        logic [RUN_CFG_BITS-1:0] run_length;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } point_t;

    // Commands from the sequencer to the filter
    typedef struct packed {
        logic step;   // run the point through the filter
        logic load;   // take the point as the held point
        logic clear;  // drop the held point at profile end
    } filt_ctrl_t;

    // Zero-extend a threshold register to the compare width
    function automatic logic signed [CMP_BITS-1:0] thr_ext(input logic [CFG_BITS-1:0] v);
        return $signed({{(CMP_BITS - CFG_BITS){1'b0}}, v});
    endfunction

endpackage

[design/podf_window_ram.sv]
// ============================================================================
// podf_window_ram
// Window memory for the points seen before the start: one write port, one
// read port, registered read data.
// ============================================================================
module podf_window_ram
(
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [podf_pkg::SLOT_BITS-1:0]      wr_addr,
    input  podf_pkg::point_t                    wr_data,
    input  logic                                rd_en,
    input  logic [podf_pkg::SLOT_BITS-1:0]      rd_addr,
    output podf_pkg::point_t                    rd_data
);

    podf_pkg::point_t mem [podf_pkg::MAX_RUN];
    podf_pkg::point_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/podf_filter.sv]
// ============================================================================
// podf_filter
// Spacing, drop and rise filter around the held (last kept) point.
// ============================================================================
module podf_filter
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  podf_pkg::cfg_t        cfg,
    input  podf_pkg::filt_ctrl_t  ctrl,
    input  podf_pkg::point_t      pt,
    output logic                  emit,
    output podf_pkg::point_t      held,
    output logic                  held_valid
);

    podf_pkg::point_t held_reg;
    logic             held_valid_reg;
    logic             held_valid_next;

    logic signed [podf_pkg::CMP_BITS-1:0] dx;
    logic signed [podf_pkg::CMP_BITS-1:0] dy;
    logic signed [podf_pkg::CMP_BITS-1:0] drop_neg;
    logic                                 skip_near;
    logic                                 skip_drop;
    logic                                 rise;
    logic                                 keep;

    // Differences against the held point, wide enough to never wrap
    assign dx = podf_pkg::CMP_BITS'($signed(pt.x)) - podf_pkg::CMP_BITS'($signed(held_reg.x));
    assign dy = podf_pkg::CMP_BITS'($signed(pt.y)) - podf_pkg::CMP_BITS'($signed(held_reg.y));
    assign drop_neg = -podf_pkg::thr_ext(cfg.drop_step_y);

    // Classify the point
    assign skip_near = dx < podf_pkg::thr_ext(cfg.min_step_x);
    assign skip_drop = (dy < drop_neg) && (dx < podf_pkg::thr_ext(cfg.drop_window_x));
    assign rise      = (dy > podf_pkg::thr_ext(cfg.rise_step_y))
                    && (dx < podf_pkg::thr_ext(cfg.rise_window_x));
    assign keep      = !skip_near && !skip_drop;

    // Send the held point when a later point is kept normally
    assign emit = ctrl.step && keep && !rise;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        if (ctrl.load)
        begin
            held_valid_next = 1'b1;
        end
        else if (ctrl.clear)
        begin
            held_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
        end
    end

    // Replace the held point on load, on a rise and on a normal keep
    always_ff @(posedge clk)
    begin
        if (ctrl.load || (ctrl.step && keep))
        begin
            held_reg <= pt;
        end
    end

    assign held       = held_reg;
    assign held_valid = held_valid_reg;

endmodule

[design/profile_occlusion_density_filter_unit.sv]
// ============================================================================
// profile_occlusion_density_filter_unit
// Finds the start of a sorted profile, replays the window memory behind it
// and filters the points that follow for spacing, early drops and rises.
// ============================================================================
//
//  channel | signals                              | handshake
//  --------+--------------------------------------+-----------------------
//  point   | x_pos, y_pos, end_of_profile         | pt_valid / pt_stall
//  result  | out_x, out_y, out_last, none_found   | res_valid / res_stall
//  config  | cfg_index, cfg_data                  | cfg_valid / cfg_ready
//
//  A point before or after the start is handled in ST_IDLE; the final point
//  of a started profile also goes through ST_FLUSH to flush the held point.
//  Finding the start replays the clamped run length of points (none when it
//  is one) from the window memory, each via ST_READ (read), then ST_USE
//  (filter). A stalled result register holds off the next transaction on
//  the point channel and pauses the replay. Reset needs no clearing pass.
//
module profile_occlusion_density_filter_unit
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    // point channel
    input  logic                                      pt_valid,
    output logic                                      pt_stall,
    input  logic signed [podf_pkg::COORD_BITS-1:0]    x_pos,
    input  logic signed [podf_pkg::COORD_BITS-1:0]    y_pos,
    input  logic                                      end_of_profile,
    // result channel
    output logic                                      res_valid,
    input  logic                                      res_stall,
    output logic signed [podf_pkg::COORD_BITS-1:0]    out_x,
    output logic signed [podf_pkg::COORD_BITS-1:0]    out_y,
    output logic                                      out_last,
    output logic                                      none_found,
    // configuration channel
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [podf_pkg::CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [podf_pkg::CFG_BITS-1:0]             cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_USE,
        ST_FLUSH
    } state_t;

    localparam int SB = podf_pkg::SLOT_BITS;
    localparam int RB = podf_pkg::RUN_BITS;

    // Advance a window slot, wrapping at the window depth
    function automatic logic [SB-1:0] next_slot(input logic [SB-1:0] s);
        if (s == SB'(podf_pkg::MAX_RUN - 1))
        begin
            return '0;
        end
        return s + SB'(1);
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    podf_pkg::cfg_t   cfg_reg;
    state_t           state_reg,        state_next;
    logic [SB-1:0]    write_slot_reg,   write_slot_next;
    logic [RB-1:0]    clean_run_reg,    clean_run_next;
    logic             started_reg,      started_next;
    logic [SB-1:0]    rd_ptr_reg,       rd_ptr_next;
    logic [RB-1:0]    replay_cnt_reg,   replay_cnt_next;
    logic             replay_first_reg, replay_first_next;
    logic             end_pend_reg,     end_pend_next;
    logic             res_valid_reg,    res_valid_next;
    logic signed [podf_pkg::COORD_BITS-1:0] last_y_reg;
    podf_pkg::point_t res_pt_reg;
    logic             res_last_reg;
    logic             res_none_reg;

    // ------------------------------------------------------------------
    // Datapath signals
    // ------------------------------------------------------------------
    logic                                 out_free;
    logic                                 accept;
    podf_pkg::point_t                     in_pt;
    logic [RB-1:0]                        run_eff;
    logic signed [podf_pkg::CMP_BITS-1:0] up_step;
    logic                                 jump;
    logic [RB-1:0]                        run_base;
    logic [RB-1:0]                        run_new;
    logic                                 start_hit;
    logic [SB-1:0]                        back;
    logic [SB-1:0]                        first_slot;

    logic                                 ram_wr_en;
    logic                                 ram_rd_en;
    podf_pkg::point_t                     ram_rd_data;

    podf_pkg::filt_ctrl_t                 fctrl;
    podf_pkg::point_t                     fpt;
    logic                                 f_emit;
    podf_pkg::point_t                     f_held;
    logic                                 f_held_valid;

    logic                                 out_load;
    podf_pkg::point_t                     out_pt;
    logic                                 out_last_bit;
    logic                                 out_none_bit;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_step_x    <= podf_pkg::RST_MIN_STEP_X;
            cfg_reg.drop_step_y   <= podf_pkg::RST_DROP_STEP_Y;
            cfg_reg.drop_window_x <= podf_pkg::RST_DROP_WINDOW_X;
            cfg_reg.rise_step_y   <= podf_pkg::RST_RISE_STEP_Y;
            cfg_reg.rise_window_x <= podf_pkg::RST_RISE_WINDOW_X;
            cfg_reg.jump_limit    <= podf_pkg::RST_JUMP_LIMIT;
            cfg_reg.run_length    <= podf_pkg::RST_RUN_LENGTH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                podf_pkg::REG_MIN_STEP_X:    cfg_reg.min_step_x    <= cfg_data;
                podf_pkg::REG_DROP_STEP_Y:   cfg_reg.drop_step_y   <= cfg_data;
                podf_pkg::REG_DROP_WINDOW_X: cfg_reg.drop_window_x <= cfg_data;
                podf_pkg::REG_RISE_STEP_Y:   cfg_reg.rise_step_y   <= cfg_data;
                podf_pkg::REG_RISE_WINDOW_X: cfg_reg.rise_window_x <= cfg_data;
                podf_pkg::REG_JUMP_LIMIT:    cfg_reg.jump_limit    <= cfg_data;
                podf_pkg::REG_RUN_LENGTH:
                    cfg_reg.run_length <= cfg_data[podf_pkg::RUN_CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign out_free = !res_valid_reg || !res_stall;
    assign pt_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept   = pt_valid && !pt_stall;
    assign in_pt.x  = x_pos;
    assign in_pt.y  = y_pos;

    // ------------------------------------------------------------------
    // Start search: clamp the run length, track the jump-free run
    // ------------------------------------------------------------------
    always_comb
    begin
        if (cfg_reg.run_length == '0)
        begin
            run_eff = RB'(1);
        end
        else if (32'(cfg_reg.run_length) > 32'(podf_pkg::MAX_RUN))
        begin
            run_eff = RB'(podf_pkg::MAX_RUN);
        end
        else
        begin
            run_eff = RB'(cfg_reg.run_length);
        end
    end

    assign up_step  = podf_pkg::CMP_BITS'($signed(y_pos))
                    - podf_pkg::CMP_BITS'($signed(last_y_reg));
    assign jump     = (clean_run_reg != '0) && (up_step >= podf_pkg::thr_ext(cfg_reg.jump_limit));
    assign run_base = jump ? '0 : clean_run_reg;
    assign run_new  = (run_base < RB'(podf_pkg::MAX_RUN)) ? run_base + RB'(1) : run_base;
    assign start_hit = run_new >= run_eff;

    // Oldest slot of the start window, wrapping below slot zero
    assign back = SB'(run_eff - RB'(1));
    always_comb
    begin
        if (write_slot_reg >= back)
        begin
            first_slot = write_slot_reg - back;
        end
        else
        begin
            first_slot = SB'((SB+1)'(write_slot_reg) + (SB+1)'(podf_pkg::MAX_RUN)
                           - (SB+1)'(back));
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        write_slot_next   = write_slot_reg;
        clean_run_next    = clean_run_reg;
        started_next      = started_reg;
        rd_ptr_next       = rd_ptr_reg;
        replay_cnt_next   = replay_cnt_reg;
        replay_first_next = replay_first_reg;
        end_pend_next     = end_pend_reg;
        ram_wr_en         = 1'b0;
        ram_rd_en         = 1'b0;
        fctrl             = '0;
        fpt               = in_pt;
        out_load          = 1'b0;
        out_pt            = f_held;
        out_last_bit      = 1'b0;
        out_none_bit      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (started_reg)
                    begin
                        // Filter the new point against the held one
                        fctrl.step = 1'b1;
                        if (end_of_profile)
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                    else
                    begin
                        // Store the point and extend the run
                        ram_wr_en       = 1'b1;
                        clean_run_next  = run_new;
                        write_slot_next = next_slot(write_slot_reg);
                        if (start_hit)
                        begin
                            started_next = 1'b1;
                            if (run_eff == RB'(1))
                            begin
                                fctrl.load = 1'b1;
                                if (end_of_profile)
                                begin
                                    state_next = ST_FLUSH;
                                end
                            end
                            else
                            begin
                                rd_ptr_next       = first_slot;
                                replay_cnt_next   = run_eff - RB'(1);
                                replay_first_next = 1'b1;
                                end_pend_next     = end_of_profile;
                                state_next        = ST_READ;
                            end
                        end
                        else if (end_of_profile)
                        begin
                            // No start in this profile
                            out_load     = 1'b1;
                            out_pt       = '0;
                            out_last_bit = 1'b1;
                            out_none_bit = 1'b1;
                        end
                    end
                    if (end_of_profile)
                    begin
                        write_slot_next = '0;
                        clean_run_next  = '0;
                    end
                end
            end

            ST_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = ST_USE;
            end

            ST_USE:
            begin
                fpt = ram_rd_data;
                if (replay_first_reg)
                begin
                    // Oldest window point becomes the held point
                    fctrl.load        = 1'b1;
                    replay_first_next = 1'b0;
                    rd_ptr_next       = next_slot(rd_ptr_reg);
                    state_next        = ST_READ;
                end
                else if (out_free)
                begin
                    fctrl.step      = 1'b1;
                    replay_cnt_next = replay_cnt_reg - RB'(1);
                    rd_ptr_next     = next_slot(rd_ptr_reg);
                    if (replay_cnt_reg == RB'(1))
                    begin
                        state_next = end_pend_reg ? ST_FLUSH : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end

            ST_FLUSH:
            begin
                // Send the held point as the last result of the profile
                if (out_free)
                begin
                    out_load     = 1'b1;
                    out_pt       = f_held;
                    out_last_bit = 1'b1;
                    out_none_bit = !f_held_valid;
                    fctrl.clear  = 1'b1;
                    started_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Normal keep from the filter sends the previously held point
        if (f_emit)
        begin
            out_load     = 1'b1;
            out_pt       = f_held;
            out_last_bit = 1'b0;
            out_none_bit = 1'b0;
        end

        // Result register: load, or drop when taken
        if (out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            write_slot_reg   <= '0;
            clean_run_reg    <= '0;
            started_reg      <= 1'b0;
            rd_ptr_reg       <= '0;
            replay_cnt_reg   <= '0;
            replay_first_reg <= 1'b0;
            end_pend_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
            res_pt_reg       <= '0;
            res_last_reg     <= 1'b0;
            res_none_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            write_slot_reg   <= write_slot_next;
            clean_run_reg    <= clean_run_next;
            started_reg      <= started_next;
            rd_ptr_reg       <= rd_ptr_next;
            replay_cnt_reg   <= replay_cnt_next;
            replay_first_reg <= replay_first_next;
            end_pend_reg     <= end_pend_next;
            res_valid_reg    <= res_valid_next;
            if (out_load)
            begin
                res_pt_reg   <= out_pt;
                res_last_reg <= out_last_bit;
                res_none_reg <= out_none_bit;
            end
        end
    end

    // Hold the last stored y for the jump check
    always_ff @(posedge clk)
    begin
        if (ram_wr_en)
        begin
            last_y_reg <= y_pos;
        end
    end

    assign res_valid  = res_valid_reg;
    assign out_x      = res_pt_reg.x;
    assign out_y      = res_pt_reg.y;
    assign out_last   = res_last_reg;
    assign none_found = res_none_reg;

    // ------------------------------------------------------------------
    // Window memory and filter
    // ------------------------------------------------------------------
    podf_window_ram u_window_ram
    (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (write_slot_reg),
        .wr_data (in_pt),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    podf_filter u_filter
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .ctrl       (fctrl),
        .pt         (fpt),
        .emit       (f_emit),
        .held       (f_held),
        .held_valid (f_held_valid)
    );

endmodule
